>>> design/checked_command_exchange_unit_macros.svh
// ---------------------------------------------------------------------------
// Checked command exchange unit: assertion macros
// Shared assertion forms for the checker of the exchange unit.
// ---------------------------------------------------------------------------
`ifndef CHECKED_COMMAND_EXCHANGE_UNIT_MACROS_SVH
`define CHECKED_COMMAND_EXCHANGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("checked_command_exchange_unit: property violated");

// Next-cycle implication, disabled while reset is asserted.
`define CCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("checked_command_exchange_unit: property violated");

`endif

>>> design/cce_pkg.sv
// ---------------------------------------------------------------------------
// Checked command exchange: shared package
// Types, codes and constants used by the exchange unit modules.
// ---------------------------------------------------------------------------
package cce_pkg;

	// Response store depth and the width of the kept-byte counter.
	localparam int RESP_DEPTH = 256;
	localparam int CNT_W      = $clog2(RESP_DEPTH + 1);

	// Result queue.
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;
	localparam logic [1:0]  MODE_RESET    = 2'd0;
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Input function codes.
	localparam logic [1:0] FUNC_CMD_BYTE = 2'd0;
	localparam logic [1:0] FUNC_CMD_END  = 2'd1;
	localparam logic [1:0] FUNC_RX       = 2'd2;
	localparam logic [1:0] FUNC_TICK     = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_XMIT = 2'd0;
	localparam logic [1:0] KIND_RESP = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	// Exchange status codes.
	localparam logic [3:0] ST_OK            = 4'd0;
	localparam logic [3:0] ST_ECHO_TIMEOUT  = 4'd1;
	localparam logic [3:0] ST_ECHO_EXTRA    = 4'd2;
	localparam logic [3:0] ST_ECHO_BAD      = 4'd3;
	localparam logic [3:0] ST_RESP_TIMEOUT  = 4'd4;
	localparam logic [3:0] ST_BEL           = 4'd5;
	localparam logic [3:0] ST_BEL_EXTRA     = 4'd6;
	localparam logic [3:0] ST_OVERFLOW      = 4'd7;
	localparam logic [3:0] ST_SUM_TIMEOUT   = 4'd8;
	localparam logic [3:0] ST_SUM_EXTRA     = 4'd9;
	localparam logic [3:0] ST_SUM_BAD       = 4'd10;

	// Cancel handshake outcomes.
	localparam logic [2:0] CAN_NONE    = 3'd0;
	localparam logic [2:0] CAN_ECHOED  = 3'd1;
	localparam logic [2:0] CAN_TIMEOUT = 3'd2;
	localparam logic [2:0] CAN_EXTRA   = 3'd3;
	localparam logic [2:0] CAN_WRONG   = 3'd4;

	// Line characters.
	localparam logic [7:0] CH_SO  = 8'h0E;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_ACK = 8'h06;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_CAN = 8'h18;
	localparam logic [7:0] CH_MSB = 8'h80;

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_CMD    = 6'b000010,
		PH_ECHO   = 6'b000100,
		PH_RESP   = 6'b001000,
		PH_SUM    = 6'b010000,
		PH_CANCEL = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic [3:0] status;
		logic [2:0] cancel_result;
		logic [8:0] response_length;
		logic       last;
	} result_t;

	// Up to two results produced by one transaction.
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] byte_val,
			input logic [3:0] st, input logic [2:0] cres, input logic [8:0] len);
		result_t r;
		r.kind            = kind;
		r.out_byte        = byte_val;
		r.status          = st;
		r.cancel_result   = cres;
		r.response_length = len;
		r.last            = 1'b0;
		return r;
	endfunction

endpackage

>>> design/cce_regs.sv
// ---------------------------------------------------------------------------
// Checked command exchange: configuration registers
// APB-style register file holding the checksum mode and the timeout.
// ---------------------------------------------------------------------------
module cce_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cce_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output logic [1:0]                     checksum_mode,
	output logic [15:0]                    timeout_ticks
);
	import cce_pkg::*;

	logic [1:0]  mode_q;
	logic [15:0] timeout_q;
	logic        reg_sel;
	logic        wr_en;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MODE:    mode_q    <= pwdata[1:0];
				REG_TIMEOUT: timeout_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_MODE:    prdata = {30'd0, mode_q};
			REG_TIMEOUT: prdata = {16'd0, timeout_q};
		endcase
	end

	assign checksum_mode = mode_q;
	assign timeout_ticks = timeout_q;

endmodule

>>> design/cce_core.sv
// ---------------------------------------------------------------------------
// Checked command exchange: exchange engine
// Input register, exchange state and the per-transaction next-state logic.
// ---------------------------------------------------------------------------
module cce_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  logic [1:0]           func,
	input  logic [7:0]           data_byte,
	input  logic                 more_queued,
	input  logic [1:0]           checksum_mode,
	input  logic [15:0]          timeout_ticks,
	input  logic                 room,
	output cce_pkg::push_t       push
);
	import cce_pkg::*;

	// Input stage.
	logic        s1_valid_q;
	logic [1:0]  func_s1;
	logic [7:0]  data_s1;
	logic        mq_s1;
	logic        fire;
	logic        accept;

	// Exchange state.
	phase_t           phase_q, phase_d;
	logic [7:0]       sum_q, sum_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [15:0]      prev_q, prev_d;
	logic [15:0]      wait_q, wait_d;
	logic [3:0]       held_q, held_d;

	// Working values.
	logic [CNT_W-1:0] cnt_inc;
	logic [15:0]      prev_shift;
	logic [15:0]      wait_inc;
	logic [15:0]      limit;
	logic [7:0]       base_sum;

	logic       pre_valid;
	logic       do_xmit;
	logic       do_cancel;
	logic       do_finish;
	logic [7:0] xmit_byte;
	logic [3:0] act_status;
	logic [2:0] act_cres;
	result_t    pre_res;
	result_t    act_res;

	assign fire      = s1_valid_q & room;
	assign cmd_stall = s1_valid_q & ~room;
	assign accept    = cmd_valid & ~cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			data_s1 <= data_byte;
			mq_s1   <= more_queued;
		end
	end

	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign prev_shift = {prev_q[7:0], data_s1};
	assign wait_inc   = (wait_q != 16'hFFFF) ? (wait_q + 16'd1) : wait_q;
	assign limit      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
	assign base_sum   = (phase_q == PH_IDLE) ? 8'd0 : sum_q;

	always_comb begin
		phase_d    = phase_q;
		sum_d      = sum_q;
		cnt_d      = cnt_q;
		prev_d     = prev_q;
		wait_d     = wait_q;
		held_d     = held_q;
		pre_valid  = 1'b0;
		do_xmit    = 1'b0;
		do_cancel  = 1'b0;
		do_finish  = 1'b0;
		xmit_byte  = 8'd0;
		act_status = ST_OK;
		act_cres   = CAN_NONE;

		if (fire) begin
			unique case (func_s1)
				FUNC_CMD_BYTE, FUNC_CMD_END: begin
					if (phase_q == PH_IDLE || phase_q == PH_CMD) begin
						// A new command clears what the last exchange left.
						if (phase_q == PH_IDLE) begin
							cnt_d   = '0;
							prev_d  = 16'd0;
							held_d  = ST_OK;
							wait_d  = 16'd0;
							phase_d = PH_CMD;
						end
						do_xmit = 1'b1;
						if (func_s1 == FUNC_CMD_BYTE) begin
							sum_d     = checksum_mode[0] ? (base_sum ^ data_s1)
							                             : (base_sum + data_s1);
							xmit_byte = data_s1;
						end else begin
							sum_d     = checksum_mode[1] ? (base_sum | CH_MSB) : base_sum;
							phase_d   = PH_ECHO;
							wait_d    = 16'd0;
							xmit_byte = CH_SO;
						end
					end
				end
				FUNC_RX: begin
					wait_d = 16'd0;
					unique case (phase_q)
						PH_ECHO: begin
							if (mq_s1) begin
								do_cancel  = 1'b1;
								act_status = ST_ECHO_EXTRA;
							end else if (data_s1 != sum_q) begin
								do_cancel  = 1'b1;
								act_status = ST_ECHO_BAD;
							end else begin
								phase_d   = PH_RESP;
								cnt_d     = '0;
								prev_d    = 16'd0;
								do_xmit   = 1'b1;
								xmit_byte = CH_CR;
							end
						end
						PH_RESP: begin
							if (cnt_q == '0 && data_s1 == CH_BEL) begin
								// A leading BEL is not kept.
								if (mq_s1) begin
									do_cancel  = 1'b1;
									act_status = ST_BEL_EXTRA;
								end else begin
									do_finish  = 1'b1;
									act_status = ST_BEL;
								end
							end else if (cnt_q == '0 && data_s1 == CH_ACK) begin
								pre_valid = 1'b1;
								cnt_d     = CNT_W'(1);
								prev_d    = {8'd0, data_s1};
								phase_d   = PH_SUM;
							end else begin
								pre_valid = 1'b1;
								cnt_d     = cnt_inc;
								prev_d    = prev_shift;
								if (cnt_inc >= CNT_W'(RESP_DEPTH)) begin
									do_finish  = 1'b1;
									act_status = ST_OVERFLOW;
								end else if (cnt_inc >= CNT_W'(4) && prev_q[15:8] == CH_CR &&
										data_s1 == CH_ACK) begin
									phase_d = PH_SUM;
								end
							end
						end
						PH_SUM: begin
							pre_valid = 1'b1;
							cnt_d     = cnt_inc;
							prev_d    = prev_shift;
							if (mq_s1) begin
								do_cancel  = 1'b1;
								act_status = ST_SUM_EXTRA;
							end else if (data_s1 != sum_q) begin
								do_cancel  = 1'b1;
								act_status = ST_SUM_BAD;
							end else begin
								do_finish  = 1'b1;
								act_status = ST_OK;
							end
						end
						PH_CANCEL: begin
							do_finish  = 1'b1;
							act_status = held_q;
							if (mq_s1) begin
								act_cres = CAN_EXTRA;
							end else if (data_s1 == CH_CAN) begin
								act_cres = CAN_ECHOED;
							end else begin
								act_cres = CAN_WRONG;
							end
						end
						default: begin
						end
					endcase
				end
				FUNC_TICK: begin
					if (phase_q == PH_ECHO || phase_q == PH_RESP || phase_q == PH_SUM ||
							phase_q == PH_CANCEL) begin
						if (wait_inc >= limit) begin
							unique case (phase_q)
								PH_ECHO: begin
									do_cancel  = 1'b1;
									act_status = ST_ECHO_TIMEOUT;
								end
								PH_RESP: begin
									do_cancel  = 1'b1;
									act_status = ST_RESP_TIMEOUT;
								end
								PH_SUM: begin
									do_cancel  = 1'b1;
									act_status = ST_SUM_TIMEOUT;
								end
								default: begin
									do_finish  = 1'b1;
									act_status = held_q;
									act_cres   = CAN_TIMEOUT;
								end
							endcase
						end else begin
							wait_d = wait_inc;
						end
					end
				end
			endcase
		end

		// Closing actions shared by every path.
		if (do_cancel) begin
			held_d  = act_status;
			phase_d = PH_CANCEL;
			wait_d  = 16'd0;
		end
		if (do_finish) begin
			phase_d = PH_IDLE;
			wait_d  = 16'd0;
		end
	end

	always_comb begin
		pre_res = mk_result(KIND_RESP, data_s1, ST_OK, CAN_NONE, 9'd0);
		if (do_cancel) begin
			act_res = mk_result(KIND_XMIT, CH_CAN, ST_OK, CAN_NONE, 9'd0);
		end else if (do_finish) begin
			act_res = mk_result(KIND_DONE, 8'd0, act_status, act_cres, 9'(cnt_d));
		end else begin
			act_res = mk_result(KIND_XMIT, xmit_byte, ST_OK, CAN_NONE, 9'd0);
		end

		push    = '0;
		push.r1 = act_res;
		if (pre_valid) begin
			push.r0 = pre_res;
			if (do_xmit || do_cancel || do_finish) begin
				push.num     = 2'd2;
				push.r1.last = 1'b1;
			end else begin
				push.num     = 2'd1;
				push.r0.last = 1'b1;
			end
		end else begin
			push.r0 = act_res;
			if (do_xmit || do_cancel || do_finish) begin
				push.num     = 2'd1;
				push.r0.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sum_q   <= 8'd0;
			cnt_q   <= '0;
			prev_q  <= 16'd0;
			wait_q  <= 16'd0;
			held_q  <= ST_OK;
		end else begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			cnt_q   <= cnt_d;
			prev_q  <= prev_d;
			wait_q  <= wait_d;
			held_q  <= held_d;
		end
	end

endmodule

>>> design/cce_out_fifo.sv
// ---------------------------------------------------------------------------
// Checked command exchange: result queue
// Small queue that takes up to two results a cycle and hands out one.
// ---------------------------------------------------------------------------
module cce_out_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  cce_pkg::push_t   push,
	input  logic             pop,
	output cce_pkg::result_t head,
	output logic             not_empty,
	output logic             room
);
	import cce_pkg::*;

	result_t              mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]  wr_q;
	logic [OQ_PTR_W-1:0]  rd_q;
	logic [OQ_CNT_W-1:0]  count_q;
	logic [OQ_PTR_W-1:0]  wr_next;

	assign wr_next   = wr_q + OQ_PTR_W'(1);
	assign not_empty = (count_q != '0);
	// Space for the two results a single transaction may produce.
	assign room      = (count_q <= OQ_CNT_W'(OQ_DEPTH - 2));
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + OQ_PTR_W'(push.num);
			rd_q    <= rd_q + OQ_PTR_W'(pop);
			count_q <= count_q + OQ_CNT_W'(push.num) - OQ_CNT_W'(pop);
		end
	end

endmodule

>>> design/checked_command_exchange_unit.sv
// ---------------------------------------------------------------------------
// Checked command exchange unit
// Each input transaction is registered in the input stage, and its results in
// the result queue before they show. Throughput: one input transaction per
// cycle; results leave one at a time, and the input stalls once the result
// queue cannot take two more. Reset (arst_n low) returns the exchange to
// idle, empties the queue and loads checksum mode 0 and timeout 1000.
// ---------------------------------------------------------------------------
module checked_command_exchange_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// Event channel: command bytes, command end, line bytes and ticks.
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  logic [1:0]                     func,
	input  logic [7:0]                     data_byte,
	input  logic                           more_queued,
	// Result channel.
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [1:0]                     kind,
	output logic [7:0]                     out_byte,
	output logic [3:0]                     status,
	output logic [2:0]                     cancel_result,
	output logic [8:0]                     response_length,
	output logic                           last,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cce_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import cce_pkg::*;

	logic [1:0]  checksum_mode;
	logic [15:0] timeout_ticks;
	logic        room;
	logic        pop;
	push_t       push;
	result_t     head;

	// Register 0 (byte address 0) holds the checksum mode, register 1 (byte
	// address 4) the tick limit for each awaited line byte. The user must rewrite
	// both only while no exchange is in progress; the block does not enforce it.
	cce_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.checksum_mode (checksum_mode),
		.timeout_ticks (timeout_ticks)
	);

	// The engine registers each accepted transaction, then, once the queue has
	// room, updates the exchange state and pushes its zero, one or two results into
	// the queue. It only retires a transaction when the queue has space for
	// two results, so nothing is ever dropped. A response byte followed by a
	// CAN or by the done report is the two-result case.
	cce_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.func          (func),
		.data_byte     (data_byte),
		.more_queued   (more_queued),
		.checksum_mode (checksum_mode),
		.timeout_ticks (timeout_ticks),
		.room          (room),
		.push          (push)
	);

	// The queue decouples the engine from a stalled consumer: new input
	// transactions keep flowing while earlier results wait, until the queue lacks room for two.
	cce_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (pop),
		.head      (head),
		.not_empty (res_valid),
		.room      (room)
	);

	assign pop = res_valid & ~res_stall;

	assign kind            = head.kind;
	assign out_byte        = head.out_byte;
	assign status          = head.status;
	assign cancel_result   = head.cancel_result;
	assign response_length = head.response_length;
	assign last            = head.last;

endmodule

>>> design/cce_checker.sv
// ---------------------------------------------------------------------------
// Checked command exchange: port checker
// Port-level properties of the exchange unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "checked_command_exchange_unit_macros.svh"

module cce_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic [3:0] status,
	input logic [2:0] cancel_result,
	input logic [8:0] response_length,
	input logic       last
);
	import cce_pkg::*;

	// A stalled result stays in place.
	`CCE_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(out_byte) && $stable(kind) && $stable(last))

	// Only the done report carries status, cancel outcome and length.
	`CCE_ASSERT_IMPLIES(a_plain_fields_zero, clk, arst_n, res_valid && kind != KIND_DONE, status == ST_OK && cancel_result == CAN_NONE && response_length == 9'd0)

	// The done report always closes the results of its transaction.
	`CCE_ASSERT_IMPLIES(a_done_is_last, clk, arst_n, res_valid && kind == KIND_DONE, last)

	// A CAN handshake took place exactly for every status other than OK, BEL and overflow.
	`CCE_ASSERT_IMPLIES(a_cancel_matches_status, clk, arst_n, res_valid && kind == KIND_DONE, (cancel_result == CAN_NONE) == (status == ST_OK || status == ST_BEL || status == ST_OVERFLOW))

endmodule

bind checked_command_exchange_unit cce_checker u_cce_checker (.*);
